[hw/rtl/sorted_key_table_core_assert.svh]
// Assertion macros for the sorted key table. They expect clk_i and rst_ni in scope.
`ifndef SORTED_KEY_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define SKT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sorted key table check failed");
// Checked at every edge, reset included.
`define SKT_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("sorted key table check failed");
`else
`define SKT_ASSERT(lbl, prop)
`define SKT_ASSERT_ANY(lbl, prop)
`endif
`endif

[hw/rtl/skt_pkg.sv]
`timescale 1ns / 1ps
package skt_pkg;

  // Default sizes of the table.
  localparam int unsigned DEPTH_DEFAULT = 32;
  localparam int unsigned PAY_W_DEFAULT = 32;

  // Operation codes of the mode field.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_FIND   = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_NOMATCH = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_BAD     = 3'd5
  } status_e;

  // Outcome of the shared key comparator.
  typedef struct packed {
    logic lt_lo;  // operand below the low key
    logic eq_lo;  // operand equal to the low key
    logic gt_hi;  // operand above the high key
  } cmp_t;

  // One finished result word handed from the sequencer to the output register.
  typedef struct packed {
    status_e     status;
    logic [31:0] found_payload;
    logic [5:0]  removed_count;
    logic [5:0]  entry_count;
  } res_t;

endpackage

[hw/rtl/skt_store.sv]
`timescale 1ns / 1ps
module skt_store #(
  parameter int unsigned TABLE_DEPTH = skt_pkg::DEPTH_DEFAULT,
  parameter int unsigned PAY_W       = skt_pkg::PAY_W_DEFAULT,
  localparam int unsigned AddrW      = $clog2(TABLE_DEPTH)
) (
  input  logic                    clk_i,
  input  logic [AddrW-1:0]        rd_addr_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        wr_addr_i,
  input  logic signed [31:0]      wr_key_i,
  input  logic [PAY_W-1:0]        wr_pay_i,
  output logic signed [31:0]      rd_key_o,
  output logic [PAY_W-1:0]        rd_pay_o
);

  logic signed [31:0] key_mem_q [TABLE_DEPTH];
  logic [PAY_W-1:0]   pay_mem_q [TABLE_DEPTH];
  logic signed [31:0] rd_key_q;
  logic [PAY_W-1:0]   rd_pay_q;

  // Single write port for key and payload.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem_q[wr_addr_i] <= wr_key_i;
      pay_mem_q[wr_addr_i] <= wr_pay_i;
    end
  end

  // Registered read port; a read of the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem_q[rd_addr_i];
    rd_pay_q <= pay_mem_q[rd_addr_i];
  end

  assign rd_key_o = rd_key_q;
  assign rd_pay_o = rd_pay_q;

endmodule

[hw/rtl/skt_kcmp.sv]
`timescale 1ns / 1ps
module skt_kcmp (
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] lo_i,
  input  logic signed [31:0] hi_i,
  output skt_pkg::cmp_t      cmp_o
);

  // Signed compares of one operand against the low and high keys.
  always_comb begin
    cmp_o.lt_lo = (a_i < lo_i);
    cmp_o.eq_lo = (a_i == lo_i);
    cmp_o.gt_hi = (a_i > hi_i);
  end

endmodule

[hw/rtl/skt_seq.sv]
`timescale 1ns / 1ps
`include "sorted_key_table_core_assert.svh"
module skt_seq #(
  parameter int unsigned TABLE_DEPTH = skt_pkg::DEPTH_DEFAULT,
  parameter int unsigned PAY_W       = skt_pkg::PAY_W_DEFAULT,
  localparam int unsigned AddrW      = $clog2(TABLE_DEPTH),
  localparam int unsigned CntW       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request word.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] key_upper_i,
  input  logic [PAY_W-1:0]   pay_i,
  // Memory port.
  output logic [AddrW-1:0]   rd_addr_o,
  output logic               we_o,
  output logic [AddrW-1:0]   wr_addr_o,
  output logic signed [31:0] wr_key_o,
  output logic [PAY_W-1:0]   wr_pay_o,
  input  logic signed [31:0] rd_key_i,
  input  logic [PAY_W-1:0]   rd_pay_i,
  // Shared comparator.
  output logic signed [31:0] cmp_a_o,
  output logic signed [31:0] cmp_lo_o,
  output logic signed [31:0] cmp_hi_o,
  input  skt_pkg::cmp_t      cmp_i,
  // Finished result.
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output skt_pkg::res_t      res_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SRCH_RD  = 3'd1;
  localparam logic [2:0] S_SRCH_CMP = 3'd2;
  localparam logic [2:0] S_SHIFT    = 3'd3;
  localparam logic [2:0] S_PUT      = 3'd4;
  localparam logic [2:0] S_DEL      = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  localparam logic [CntW-1:0] CntFull = CntW'(TABLE_DEPTH);

  logic [2:0]         state_q, state_d;
  logic [1:0]         mode_q, mode_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] upper_q, upper_d;
  logic [PAY_W-1:0]   pay_q, pay_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    lo_q, lo_d;
  logic [CntW-1:0]    hi_q, hi_d;
  logic [CntW-1:0]    src_q, src_d;
  logic [CntW-1:0]    r_q, r_d;
  logic [CntW-1:0]    w_q, w_d;
  logic [CntW-1:0]    rm_q, rm_d;
  logic [AddrW-1:0]   mid_q, mid_d;
  logic [AddrW-1:0]   pend_addr_q, pend_addr_d;
  logic               eq_q, eq_d;
  logic               pend_q, pend_d;
  skt_pkg::status_e   status_q, status_d;
  logic [31:0]        found_q, found_d;

  logic [CntW-1:0]    span;
  logic [CntW-1:0]    mid_full;
  logic [CntW-1:0]    src_m1;
  logic [PAY_W+31:0]  pay_ext;
  logic [CntW+5:0]    cnt_ext;
  logic [CntW+5:0]    rm_ext;
  logic               in_range;

  // Midpoint of the live search window.
  assign span     = hi_q - lo_q;
  assign mid_full = lo_q + (span >> 1);
  assign src_m1   = src_q - 1'b1;
  assign pay_ext  = {32'b0, rd_pay_i};
  assign cnt_ext  = {6'b0, cnt_q};
  assign rm_ext   = {6'b0, rm_q};
  assign in_range = !cmp_i.lt_lo && !cmp_i.gt_hi;

  // The comparator checks the request range while idle, stored keys otherwise.
  assign cmp_a_o  = (state_q == S_IDLE) ? key_upper_i : rd_key_i;
  assign cmp_lo_o = (state_q == S_IDLE) ? key_i : key_q;
  assign cmp_hi_o = upper_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_FIN);

  always_comb begin
    res_o.status        = status_q;
    res_o.found_payload = found_q;
    res_o.removed_count = rm_ext[5:0];
    res_o.entry_count   = cnt_ext[5:0];
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    key_d       = key_q;
    upper_d     = upper_q;
    pay_d       = pay_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    src_d       = src_q;
    r_d         = r_q;
    w_d         = w_q;
    rm_d        = rm_q;
    mid_d       = mid_q;
    pend_addr_d = pend_addr_q;
    eq_d        = eq_q;
    pend_d      = pend_q;
    status_d    = status_q;
    found_d     = found_q;
    rd_addr_o   = '0;
    we_o        = 1'b0;
    wr_addr_o   = '0;
    wr_key_o    = key_q;
    wr_pay_o    = pay_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d   = mode_i;
          key_d    = key_i;
          upper_d  = key_upper_i;
          pay_d    = pay_i;
          found_d  = '0;
          rm_d     = '0;
          eq_d     = 1'b0;
          lo_d     = '0;
          hi_d     = cnt_q;
          r_d      = '0;
          w_d      = '0;
          pend_d   = 1'b0;
          status_d = skt_pkg::ST_BAD;
          state_d  = S_FIN;
          unique case (mode_i)
            skt_pkg::MODE_INSERT: begin
              if (key_i != 32'sd0) begin
                state_d = S_SRCH_RD;
              end
            end
            skt_pkg::MODE_FIND: begin
              if (key_i != 32'sd0) begin
                if (cnt_q == '0) begin
                  status_d = skt_pkg::ST_EMPTY;
                end else begin
                  state_d = S_SRCH_RD;
                end
              end
            end
            skt_pkg::MODE_DELETE: begin
              // The comparator sees upper against low here: upper below low is bad.
              if (!cmp_i.lt_lo) begin
                state_d = S_DEL;
              end
            end
            default: begin
              status_d = skt_pkg::ST_BAD;
            end
          endcase
        end
      end

      S_SRCH_RD: begin
        if (lo_q < hi_q) begin
          rd_addr_o = mid_full[AddrW-1:0];
          mid_d     = mid_full[AddrW-1:0];
          state_d   = S_SRCH_CMP;
        end else if (mode_q == skt_pkg::MODE_FIND) begin
          status_d = eq_q ? skt_pkg::ST_OK : skt_pkg::ST_NOMATCH;
          state_d  = S_FIN;
        end else if (eq_q) begin
          status_d = skt_pkg::ST_DUP;
          state_d  = S_FIN;
        end else if (cnt_q == CntFull) begin
          status_d = skt_pkg::ST_FULL;
          state_d  = S_FIN;
        end else begin
          src_d   = cnt_q;
          pend_d  = 1'b0;
          state_d = S_SHIFT;
        end
      end

      S_SRCH_CMP: begin
        // A key equal to the probe always lands where the search ends.
        if (cmp_i.eq_lo) begin
          eq_d = 1'b1;
          if (mode_q == skt_pkg::MODE_FIND) begin
            found_d = pay_ext[31:0];
          end
        end
        if (cmp_i.lt_lo) begin
          lo_d = CntW'({1'b0, mid_q}) + 1'b1;
        end else begin
          hi_d = CntW'({1'b0, mid_q});
        end
        state_d = S_SRCH_RD;
      end

      S_SHIFT: begin
        // Move entries up one slot, top first, one per cycle.
        we_o      = pend_q;
        wr_addr_o = pend_addr_q + 1'b1;
        wr_key_o  = rd_key_i;
        wr_pay_o  = rd_pay_i;
        if (src_q > lo_q) begin
          rd_addr_o   = src_m1[AddrW-1:0];
          pend_addr_d = src_m1[AddrW-1:0];
          src_d       = src_m1;
          pend_d      = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        we_o      = 1'b1;
        wr_addr_o = lo_q[AddrW-1:0];
        wr_key_o  = key_q;
        wr_pay_o  = pay_q;
        cnt_d     = cnt_q + 1'b1;
        status_d  = skt_pkg::ST_OK;
        state_d   = S_FIN;
      end

      S_DEL: begin
        // Read one entry a cycle; keep those outside the range, packed down.
        if (pend_q) begin
          if (in_range) begin
            rm_d = rm_q + 1'b1;
          end else begin
            we_o      = 1'b1;
            wr_addr_o = w_q[AddrW-1:0];
            wr_key_o  = rd_key_i;
            wr_pay_o  = rd_pay_i;
            w_d       = w_q + 1'b1;
          end
        end
        if (r_q < cnt_q) begin
          rd_addr_o = r_q[AddrW-1:0];
          r_d       = r_q + 1'b1;
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            cnt_d    = w_q;
            status_d = (rm_q != '0) ? skt_pkg::ST_OK : skt_pkg::ST_NOMATCH;
            state_d  = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      r_q     <= '0;
      w_q     <= '0;
      rm_q    <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      src_q   <= '0;
      eq_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      r_q     <= r_d;
      w_q     <= w_d;
      rm_q    <= rm_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      src_q   <= src_d;
      eq_q    <= eq_d;
    end
  end

  // Request and result data.
  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    key_q       <= key_d;
    upper_q     <= upper_d;
    pay_q       <= pay_d;
    mid_q       <= mid_d;
    pend_addr_q <= pend_addr_d;
    status_q    <= status_d;
    found_q     <= found_d;
  end

  `SKT_ASSERT(a_cnt_bound, cnt_q <= CntFull)
  `SKT_ASSERT(a_srch_window, (state_q == S_SRCH_RD || state_q == S_SRCH_CMP) |-> lo_q <= hi_q)
  `SKT_ASSERT(a_del_tally, state_q == S_DEL |-> ((CntW+1)'(w_q) + (CntW+1)'(rm_q) + (CntW+1)'(pend_q) == (CntW+1)'(r_q)))
  `SKT_ASSERT(a_put_room, state_q == S_PUT |-> (cnt_q < CntFull && lo_q <= cnt_q))
  `SKT_ASSERT(a_shift_floor, state_q == S_SHIFT |-> src_q >= lo_q)

endmodule

[hw/rtl/sorted_key_table_core.sv]
`timescale 1ns / 1ps
// Channel  Handshake                Word
// in       in_valid_i / in_stall_o  mode_i, key_i, key_upper_i, payload_i
// out      out_valid_o / out_stall_i status_o, found_payload_o, removed_count_o,
//                                   entry_count_o
//
// One word at a time; n is the entry count, s <= ceil(log2(n+1)) search steps.
// The single read port of the key/payload memory paces the work: each search probe
// reads a stored key and then compares it, an insert moves entries up one at a time,
// and a range delete reads every entry and writes back only those it keeps. A bad
// request or an empty find goes straight to its result; the sequencer then idles.
// Reset empties the table at once through the entry count; no clearing pass.
// A result in the output register does not block the next request; the sequencer holds
// a finished result, and stalls input, while the output register is full and stalled.
module sorted_key_table_core #(
  parameter int unsigned TABLE_DEPTH   = skt_pkg::DEPTH_DEFAULT,
  parameter int unsigned PAYLOAD_WIDTH = skt_pkg::PAY_W_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] key_upper_i,
  input  logic [31:0]        payload_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [31:0]        found_payload_o,
  output logic [5:0]         removed_count_o,
  output logic [5:0]         entry_count_o
);

  localparam int unsigned PayW  = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  logic [AddrW-1:0]   rd_addr;
  logic               we;
  logic [AddrW-1:0]   wr_addr;
  logic signed [31:0] wr_key;
  logic [PayW-1:0]    wr_pay;
  logic signed [31:0] rd_key;
  logic [PayW-1:0]    rd_pay;
  logic signed [31:0] cmp_a;
  logic signed [31:0] cmp_lo;
  logic signed [31:0] cmp_hi;
  skt_pkg::cmp_t      cmp;
  logic               res_valid;
  logic               res_ready;
  skt_pkg::res_t      res;
  logic               out_valid_q;
  skt_pkg::res_t      out_q;

  skt_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PAY_W       (PayW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .key_i       (key_i),
    .key_upper_i (key_upper_i),
    .pay_i       (payload_i[PayW-1:0]),
    .rd_addr_o   (rd_addr),
    .we_o        (we),
    .wr_addr_o   (wr_addr),
    .wr_key_o    (wr_key),
    .wr_pay_o    (wr_pay),
    .rd_key_i    (rd_key),
    .rd_pay_i    (rd_pay),
    .cmp_a_o     (cmp_a),
    .cmp_lo_o    (cmp_lo),
    .cmp_hi_o    (cmp_hi),
    .cmp_i       (cmp),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  skt_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PAY_W       (PayW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wr_key_i  (wr_key),
    .wr_pay_i  (wr_pay),
    .rd_key_o  (rd_key),
    .rd_pay_o  (rd_pay)
  );

  skt_kcmp u_kcmp (
    .a_i   (cmp_a),
    .lo_i  (cmp_lo),
    .hi_i  (cmp_hi),
    .cmp_o (cmp)
  );

  // Output register: loads when empty or when its word leaves this cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign found_payload_o = out_q.found_payload;
  assign removed_count_o = out_q.removed_count;
  assign entry_count_o   = out_q.entry_count;

endmodule
